>>> rtl/core/shortest_path_dijkstra_core_macros.svh
// Assertion macros shared by the checker files of the shortest path core.
// Needs signals named clk and rst_n in the scope where a macro is used.
`ifndef SHORTEST_PATH_DIJKSTRA_CORE_MACROS_SVH
`define SHORTEST_PATH_DIJKSTRA_CORE_MACROS_SVH

// Same-cycle implication, idle during reset.
`define SPD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, idle during reset.
`define SPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/spd_pkg.sv
// Shared types, codes and constants of the shortest path core.
// No dependencies.
package spd_pkg;

  localparam int NODES_DEF = 64;
  localparam int EDGES_DEF = 256;

  typedef logic [5:0]  node_t;
  typedef logic [31:0] dist_t;
  typedef logic [23:0] weight_t;

  localparam dist_t DIST_INF = 32'hFFFF_FFFF;
  localparam dist_t DIST_MAX = 32'hFFFF_FFFE;

  typedef enum logic [1:0] {
    KIND_CLEAR = 2'd0,
    KIND_ADD   = 2'd1,
    KIND_QUERY = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_PATH    = 2'd0,
    ST_UNREACH = 2'd1,
    ST_RANGE   = 2'd2,
    ST_UNUSED  = 2'd3
  } status_t;

  typedef struct packed {
    node_t   src;
    node_t   tgt;
    weight_t wt;
  } edge_t;

  typedef struct packed {
    logic  we;
    node_t addr;
    dist_t dval;
    node_t pred;
  } node_wr_t;

endpackage

>>> rtl/core/spd_edge_mem.sv
// Edge store of the shortest path core: one write port, one registered read port.
// Depends on spd_pkg.
module spd_edge_mem import spd_pkg::*; #(
  parameter int EDGES = EDGES_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(EDGES)-1:0] waddr,
  input  edge_t                    wdata,
  input  logic [$clog2(EDGES)-1:0] raddr,
  output edge_t                    rdata
);

  edge_t mem [EDGES];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/spd_node_mem.sv
// Per-node distance and predecessor tables with one write and one registered read.
// Depends on spd_pkg.
module spd_node_mem import spd_pkg::*; #(
  parameter int NODES = NODES_DEF
) (
  input  logic     clk,
  input  node_wr_t wr,
  input  node_t    raddr,
  output dist_t    dist_q,
  output node_t    pred_q
);

  localparam int NAW = $clog2(NODES);

  dist_t dist_mem [NODES];
  node_t pred_mem [NODES];

  // Both tables share the address of each access.
  always_ff @(posedge clk) begin
    if (wr.we) begin
      dist_mem[wr.addr[NAW-1:0]] <= wr.dval;
      pred_mem[wr.addr[NAW-1:0]] <= wr.pred;
    end
    dist_q <= dist_mem[raddr[NAW-1:0]];
    pred_q <= pred_mem[raddr[NAW-1:0]];
  end

endmodule

>>> rtl/core/spd_alu.sv
// Shared arithmetic unit: one less-than compare and one saturating distance add.
// Depends on spd_pkg.
module spd_alu import spd_pkg::*; (
  input  dist_t   cmp_a,
  input  dist_t   cmp_b,
  input  dist_t   base,
  input  weight_t wt,
  output logic    lt,
  output dist_t   sum_sat
);

  logic [32:0] sum;

  // The compare serves both the minimum search and the relaxation test.
  assign lt  = (cmp_a < cmp_b);

  // Distances clamp one below infinity.
  assign sum     = {1'b0, base} + {9'b0, wt};
  assign sum_sat = (sum > {1'b0, DIST_MAX}) ? DIST_MAX : sum[31:0];

endmodule

>>> rtl/core/shortest_path_dijkstra_core.sv
// Top level of the single-pair shortest path core: sequencer, path buffer, registers.
// Depends on spd_pkg, spd_edge_mem, spd_node_mem and spd_alu.
//
//   channel | ports                                           | direction
//   --------+-------------------------------------------------+----------
//   in      | in_valid/in_ready, kind, edges, endpoints       | request in
//   out     | out_valid/out_ready, status, node, distance     | result out
//   cfg     | cfg_valid/cfg_ready, cfg_highest_node           | register write
//
// Clear and add-edge requests are handled in the idle state. A query runs, for
// each settled node, a minimum search over nodes 0 to top and a relaxation pass
// over every stored edge, then a predecessor walk along the path and one result
// per path node. The node tables have a single read port. Reset is synchronous
// and empties the edge store; in_ready stays low while a query runs or a result
// waits on out_ready.
module shortest_path_dijkstra_core import spd_pkg::*; #(
  parameter int NODES = NODES_DEF,
  parameter int EDGES = EDGES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [5:0]  in_edge_from,
  input  logic [5:0]  in_edge_to,
  input  logic [23:0] in_edge_weight,
  input  logic [5:0]  in_start_node,
  input  logic [5:0]  in_end_node,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [5:0]  out_path_node,
  output logic [31:0] out_total_distance,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  cfg_highest_node
);

  localparam int    NAW       = $clog2(NODES);
  localparam int    EAW       = $clog2(EDGES);
  localparam node_t NODE_LAST = 6'(NODES - 1);

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_SCAN   = 13'b0000000000010,
    S_PICK   = 13'b0000000000100,
    S_EFETCH = 13'b0000000001000,
    S_EREAD  = 13'b0000000010000,
    S_ECOMP  = 13'b0000000100000,
    S_FIN    = 13'b0000001000000,
    S_FINCHK = 13'b0000010000000,
    S_WALK   = 13'b0000100000000,
    S_WALKRD = 13'b0001000000000,
    S_EMRD   = 13'b0010000000000,
    S_EMLD   = 13'b0100000000000,
    S_OUT    = 13'b1000000000000
  } state_t;

  state_t          state_r;
  node_t           highest_r;
  logic [EAW:0]    etot_r;
  logic [EAW:0]    eidx_r;
  node_t           start_r, end_r, top_r;
  logic [NODES-1:0] touched_r, settled_r;
  logic [6:0]      sidx_r;
  logic            cmp_vld_r;
  node_t           rd_node_r;
  node_t           best_r;
  dist_t           best_d_r;
  node_t           tgt_r;
  dist_t           nd_r;
  dist_t           tot_r;
  node_t           cur_r;
  logic [NAW-1:0]  pcnt_r, emidx_r;
  logic            out_vld_r;
  status_t         out_status_r;
  node_t           out_node_r;
  dist_t           out_dist_r;
  logic            out_last_r;

  node_t           pbuf [NODES];
  node_t           pbuf_q;

  node_t           valid_top;
  logic            in_acc;
  logic            edge_we;
  edge_t           edge_wdata, edge_q;
  node_wr_t        nwr;
  node_t           node_raddr;
  dist_t           dist_q, d_eff;
  node_t           pred_q;
  dist_t           cmp_a, cmp_b, sum_sat;
  logic            lt;
  logic            scan_issue;
  logic            edge_hit;
  logic            pbuf_we;

  assign valid_top  = (highest_r < NODE_LAST) ? highest_r : NODE_LAST;
  assign in_ready   = (state_r == S_IDLE);
  assign in_acc     = in_valid && in_ready;
  assign cfg_ready  = 1'b1;
  assign scan_issue = (sidx_r <= {1'b0, top_r});
  assign d_eff      = touched_r[rd_node_r[NAW-1:0]] ? dist_q : DIST_INF;
  assign edge_hit   = (edge_q.src == best_r) && (edge_q.tgt <= top_r);
  assign pbuf_we    = (state_r == S_WALK);

  // Edge store writes on an accepted add-edge request that fits.
  assign edge_we    = in_acc && (kind_t'(in_kind) == KIND_ADD) &&
                      (in_edge_from <= valid_top) && (in_edge_to <= valid_top) &&
                      (etot_r < (EAW+1)'(EDGES));
  assign edge_wdata = '{src: in_edge_from, tgt: in_edge_to, wt: in_edge_weight};

  spd_edge_mem #(.EDGES(EDGES)) u_edge_mem (
    .clk   (clk),
    .we    (edge_we),
    .waddr (etot_r[EAW-1:0]),
    .wdata (edge_wdata),
    .raddr (eidx_r[EAW-1:0]),
    .rdata (edge_q)
  );

  // Node table write and read address per sequencer step.
  always_comb begin
    nwr        = '{we: 1'b0, addr: tgt_r, dval: nd_r, pred: best_r};
    node_raddr = sidx_r[5:0];
    case (state_r)
      S_IDLE: begin
        nwr = '{we: in_acc && (kind_t'(in_kind) == KIND_QUERY), addr: in_start_node,
                dval: '0, pred: in_start_node};
      end
      S_EREAD:  node_raddr = edge_q.tgt;
      S_ECOMP:  nwr.we = lt;
      S_FIN:    node_raddr = end_r;
      S_WALK:   node_raddr = cur_r;
      default:  node_raddr = sidx_r[5:0];
    endcase
  end

  spd_node_mem #(.NODES(NODES)) u_node_mem (
    .clk    (clk),
    .wr     (nwr),
    .raddr  (node_raddr),
    .dist_q (dist_q),
    .pred_q (pred_q)
  );

  // The one compare serves the minimum search and the relaxation test.
  always_comb begin
    if (state_r == S_ECOMP) begin
      cmp_a = nd_r;
      cmp_b = d_eff;
    end else begin
      cmp_a = d_eff;
      cmp_b = best_d_r;
    end
  end

  spd_alu u_alu (
    .cmp_a   (cmp_a),
    .cmp_b   (cmp_b),
    .base    (best_d_r),
    .wt      (edge_q.wt),
    .lt      (lt),
    .sum_sat (sum_sat)
  );

  // Path buffer, written during the walk and read back in reverse.
  always_ff @(posedge clk) begin
    if (pbuf_we) begin
      pbuf[pcnt_r] <= cur_r;
    end
    pbuf_q <= pbuf[emidx_r];
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      highest_r <= 6'd63;
      etot_r    <= '0;
      out_vld_r <= 1'b0;
      cmp_vld_r <= 1'b0;
    end else begin
      rd_node_r <= node_raddr;
      if (cfg_valid && cfg_ready) begin
        highest_r <= cfg_highest_node;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            case (kind_t'(in_kind))
              KIND_CLEAR: etot_r <= '0;
              KIND_ADD: begin
                if (edge_we) begin
                  etot_r <= etot_r + 1'b1;
                end
              end
              KIND_QUERY: begin
                start_r <= in_start_node;
                end_r   <= in_end_node;
                top_r   <= valid_top;
                if (in_start_node > valid_top || in_end_node > valid_top) begin
                  out_status_r <= ST_RANGE;
                  out_node_r   <= '0;
                  out_dist_r   <= DIST_INF;
                  out_last_r   <= 1'b1;
                  out_vld_r    <= 1'b1;
                  state_r      <= S_OUT;
                end else begin
                  // Only the start node holds a distance at query start.
                  touched_r <= {{(NODES-1){1'b0}}, 1'b1} << in_start_node[NAW-1:0];
                  settled_r <= '0;
                  sidx_r    <= '0;
                  cmp_vld_r <= 1'b0;
                  best_d_r  <= DIST_INF;
                  state_r   <= S_SCAN;
                end
              end
              default: state_r <= S_IDLE;
            endcase
          end
        end
        S_SCAN: begin
          // Each read is compared in the cycle after it is issued.
          if (scan_issue) begin
            sidx_r <= sidx_r + 1'b1;
          end
          cmp_vld_r <= scan_issue;
          if (cmp_vld_r) begin
            if (!settled_r[rd_node_r[NAW-1:0]] && lt) begin
              best_d_r <= d_eff;
              best_r   <= rd_node_r;
            end
            if (rd_node_r == top_r) begin
              state_r <= S_PICK;
            end
          end
        end
        S_PICK: begin
          eidx_r <= '0;
          if (best_d_r == DIST_INF) begin
            state_r <= S_FIN;
          end else begin
            settled_r[best_r[NAW-1:0]] <= 1'b1;
            state_r <= (best_r == end_r) ? S_FIN : S_EFETCH;
          end
        end
        S_EFETCH: begin
          if (eidx_r == etot_r) begin
            sidx_r    <= '0;
            cmp_vld_r <= 1'b0;
            best_d_r  <= DIST_INF;
            state_r   <= S_SCAN;
          end else begin
            state_r <= S_EREAD;
          end
        end
        S_EREAD: begin
          if (edge_hit) begin
            tgt_r   <= edge_q.tgt;
            nd_r    <= sum_sat;
            state_r <= S_ECOMP;
          end else begin
            eidx_r  <= eidx_r + 1'b1;
            state_r <= S_EFETCH;
          end
        end
        S_ECOMP: begin
          if (lt) begin
            touched_r[tgt_r[NAW-1:0]] <= 1'b1;
          end
          eidx_r  <= eidx_r + 1'b1;
          state_r <= S_EFETCH;
        end
        S_FIN: state_r <= S_FINCHK;
        S_FINCHK: begin
          if (d_eff == DIST_INF) begin
            out_status_r <= ST_UNREACH;
            out_node_r   <= '0;
            out_dist_r   <= DIST_INF;
            out_last_r   <= 1'b1;
            out_vld_r    <= 1'b1;
            state_r      <= S_OUT;
          end else begin
            tot_r   <= d_eff;
            cur_r   <= end_r;
            pcnt_r  <= '0;
            state_r <= S_WALK;
          end
        end
        S_WALK: begin
          pcnt_r <= pcnt_r + 1'b1;
          if (cur_r == start_r) begin
            emidx_r <= pcnt_r;
            state_r <= S_EMRD;
          end else begin
            state_r <= S_WALKRD;
          end
        end
        S_WALKRD: begin
          cur_r   <= pred_q;
          state_r <= S_WALK;
        end
        S_EMRD: state_r <= S_EMLD;
        S_EMLD: begin
          out_status_r <= ST_PATH;
          out_node_r   <= pbuf_q;
          out_dist_r   <= tot_r;
          out_last_r   <= (emidx_r == '0);
          out_vld_r    <= 1'b1;
          state_r      <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) begin
            out_vld_r <= 1'b0;
            if (out_last_r) begin
              state_r <= S_IDLE;
            end else begin
              emidx_r <= emidx_r - 1'b1;
              state_r <= S_EMRD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid          = out_vld_r;
  assign out_status         = out_status_r;
  assign out_path_node      = out_node_r;
  assign out_total_distance = out_dist_r;
  assign out_last           = out_last_r;

endmodule

>>> rtl/core/spd_checker.sv
// Port-level checks of the shortest path core, bound to the top level.
// Depends on spd_pkg and shortest_path_dijkstra_core_macros.svh.
`include "shortest_path_dijkstra_core_macros.svh"

module spd_checker import spd_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [5:0]  out_path_node,
  input logic [31:0] out_total_distance,
  input logic        out_last
);

  // A waiting result blocks new requests.
  `SPD_ASSERT_NOW(a_busy_while_out, out_valid, !in_ready, "request taken with result pending")

  // Status results are single and carry infinity.
  `SPD_ASSERT_NOW(a_status_last, out_valid && (out_status != ST_PATH),
    out_last && (out_total_distance == DIST_INF), "status result malformed")

  // A path result carries a finite distance.
  `SPD_ASSERT_NOW(a_path_finite, out_valid && (out_status == ST_PATH),
    out_total_distance != DIST_INF, "path result with infinite distance")

  // A stalled result holds.
  `SPD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_path_node) && $stable(out_last), "stalled result changed")

endmodule

bind shortest_path_dijkstra_core spd_checker u_spd_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_status         (out_status),
  .out_path_node      (out_path_node),
  .out_total_distance (out_total_distance),
  .out_last           (out_last)
);
